### hw/rtl/nvms_pkg.sv
// Package for the nearest value match store.
// Holds the running total width and modulus shared by the block and its checker.
`timescale 1ns / 1ps
package nvms_pkg;
    localparam int TOTAL_W = 20;
    localparam logic [TOTAL_W-1:0] TOTAL_MOD = 20'd1000000;
endpackage

### hw/rtl/nvms_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`timescale 1ns / 1ps
module nvms_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### hw/rtl/nearest_value_match_store.sv
// Per request, from acceptance to the result register: an insert runs the search steps
// (about log2(count)+1, none on an empty store) and shifts entries in the key RAM; a match
// runs the search, two neighbor reads, the pick, the distance, a three-step modulo
// reduction by reciprocal multiplication, the add and the shifts that delete the picked key.
// A dropped insert skips the search and goes straight to the output state.
// One request at a time; the next is taken in the cycle after the result is registered,
// later while an earlier result waits. Synchronous active-low reset empties the store,
// clears the total; no RAM clearing.
`timescale 1ns / 1ps
module nearest_value_match_store #(
    parameter int CAPACITY = 1024,
    parameter int KEY_BITS = 31
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     s_axis_tvalid,
    output logic                                     s_axis_tready,
    // tdata: key
    input  logic [((KEY_BITS+7)/8)*8-1:0]            s_axis_tdata,
    // tuser: side
    input  logic                                     s_axis_tuser,
    output logic                                     m_axis_tvalid,
    input  logic                                     m_axis_tready,
    // tdata: distance, running_total, held_count, held_side
    output logic [((KEY_BITS+nvms_pkg::TOTAL_W+$clog2(CAPACITY+1)+1+7)/8)*8-1:0]
                                                     m_axis_tdata,
    // tuser: matched, dropped
    output logic [1:0]                               m_axis_tuser
);
    import nvms_pkg::*;

    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int AW  = $clog2(CAPACITY);
    localparam int OW  = ((KEY_BITS + TOTAL_W + CW + 1 + 7) / 8) * 8;
    localparam int SW  = TOTAL_W + 1;
    localparam int QS  = KEY_BITS + 9;
    localparam int RFW = QS + TOTAL_W + 1;
    localparam int RCW = (KEY_BITS > 11) ? KEY_BITS - 10 : 1;
    localparam int QW  = (KEY_BITS > 20) ? KEY_BITS - 19 : 1;
    localparam int XW  = (KEY_BITS > TOTAL_W) ? KEY_BITS : TOTAL_W;
    localparam logic [CW-1:0]  CAP_C    = CW'(CAPACITY);
    localparam logic [RFW-1:0] REC_FULL = (RFW'(1) << QS) / RFW'(TOTAL_MOD);
    localparam logic [RCW-1:0] REC      = RCW'(REC_FULL);

    typedef enum logic [4:0] {
        S_IDLE, S_SRD, S_SCMP, S_INS_RD, S_INS_WR, S_NB0, S_NB1, S_NB2,
        S_PICK, S_DIST, S_MOD, S_RED, S_FIX, S_ADD, S_DEL_RD, S_DEL_WR, S_OUT
    } t_state;

    t_state r_state;
    logic [KEY_BITS-1:0] r_key, r_lokey, r_hikey, r_sel, r_dist;
    logic                r_side, r_wside, r_ins, r_matched, r_dropped;
    logic [CW-1:0]       r_count, r_lo, r_hi, r_mid, r_idx, r_pick;
    logic [TOTAL_W-1:0]  r_total;
    logic [KEY_BITS-1:0] r_rem;
    logic [QW-1:0]       r_q;
    logic                r_ovalid, r_omatched, r_odropped, r_oside;
    logic [KEY_BITS-1:0] r_odist;
    logic [TOTAL_W-1:0]  r_ototal;
    logic [CW-1:0]       r_ocount;

    logic                    ram_we;
    logic [AW-1:0]           ram_waddr, ram_raddr;
    logic [KEY_BITS-1:0]     ram_wdata, ram_rdata;
    logic [CW:0]             mid_sum;
    logic [CW-1:0]           n_mid;
    logic [KEY_BITS-1:0]     up, dn;
    logic [KEY_BITS+RCW-1:0] rec_prod;
    logic [QW+TOTAL_W-1:0]   qm_prod;
    logic [TOTAL_W:0]        sum;

    nvms_ram #(.WIDTH(KEY_BITS), .DEPTH(CAPACITY)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign mid_sum  = {1'b0, r_lo} + {1'b0, r_hi};
    assign n_mid    = mid_sum[CW:1];
    assign up       = r_hikey - r_key;
    assign dn       = r_key - r_lokey;
    assign rec_prod = {{RCW{1'b0}}, r_rem} * {{KEY_BITS{1'b0}}, REC};
    assign qm_prod  = {{TOTAL_W{1'b0}}, r_q} * {{QW{1'b0}}, TOTAL_MOD};
    assign sum      = {1'b0, r_total} + SW'(r_rem);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_idx[AW-1:0];
        ram_wdata = ram_rdata;
        ram_raddr = n_mid[AW-1:0];
        unique case (r_state)
            S_INS_RD: begin
                if (r_idx > r_lo) begin
                    ram_raddr = AW'(r_idx - 1'b1);
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = r_lo[AW-1:0];
                    ram_wdata = r_key;
                end
            end
            S_INS_WR, S_DEL_WR: ram_we = 1'b1;
            S_NB0:    ram_raddr = (r_lo != '0) ? AW'(r_lo - 1'b1) : r_lo[AW-1:0];
            S_NB1:    ram_raddr = (r_lo < r_count) ? r_lo[AW-1:0] : AW'(r_lo - 1'b1);
            S_DEL_RD: ram_raddr = AW'(r_idx + 1'b1);
            default: ;
        endcase
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = OW'({r_oside, r_ocount, r_ototal, r_odist});
    assign m_axis_tuser  = {r_odropped, r_omatched};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_wside  <= 1'b0;
            r_total  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && m_axis_tready && (r_state != S_OUT)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_key     <= s_axis_tdata[KEY_BITS-1:0];
                        r_side    <= s_axis_tuser;
                        r_matched <= 1'b0;
                        r_dropped <= 1'b0;
                        r_dist    <= '0;
                        r_lo      <= '0;
                        r_hi      <= r_count;
                        r_ins     <= (r_count == '0) || (s_axis_tuser == r_wside);
                        if (((r_count == '0) || (s_axis_tuser == r_wside))
                            && (r_count >= CAP_C)) begin
                            r_dropped <= 1'b1;
                            r_state   <= S_OUT;
                        end else begin
                            r_state <= S_SRD;
                        end
                    end
                end
                S_SRD: begin
                    if (r_lo < r_hi) begin
                        r_mid   <= n_mid;
                        r_state <= S_SCMP;
                    end else if (r_ins) begin
                        r_idx   <= r_count;
                        r_state <= S_INS_RD;
                    end else begin
                        r_state <= S_NB0;
                    end
                end
                S_SCMP: begin
                    if (ram_rdata < r_key) begin
                        r_lo <= CW'(r_mid + 1'b1);
                    end else begin
                        r_hi <= r_mid;
                    end
                    r_state <= S_SRD;
                end
                S_INS_RD: begin
                    if (r_idx > r_lo) begin
                        r_state <= S_INS_WR;
                    end else begin
                        r_count <= CW'(r_count + 1'b1);
                        r_wside <= r_side;
                        r_state <= S_OUT;
                    end
                end
                S_INS_WR: begin
                    r_idx   <= CW'(r_idx - 1'b1);
                    r_state <= S_INS_RD;
                end
                S_NB0: r_state <= S_NB1;
                S_NB1: begin
                    r_lokey <= ram_rdata;
                    r_state <= S_NB2;
                end
                S_NB2: begin
                    r_hikey <= ram_rdata;
                    r_state <= S_PICK;
                end
                S_PICK: begin
                    // Past the end only the lower neighbor exists; at zero only the upper.
                    if (r_lo >= r_count) begin
                        r_pick <= CW'(r_lo - 1'b1);
                        r_sel  <= r_lokey;
                    end else if (r_lo == '0) begin
                        r_pick <= '0;
                        r_sel  <= r_hikey;
                    end else if (up < dn) begin
                        r_pick <= r_lo;
                        r_sel  <= r_hikey;
                    end else begin
                        r_pick <= CW'(r_lo - 1'b1);
                        r_sel  <= r_lokey;
                    end
                    r_state <= S_DIST;
                end
                S_DIST: begin
                    if (r_sel >= r_key) begin
                        r_dist <= r_sel - r_key;
                        r_rem  <= r_sel - r_key;
                    end else begin
                        r_dist <= r_key - r_sel;
                        r_rem  <= r_key - r_sel;
                    end
                    r_state <= S_MOD;
                end
                S_MOD: begin
                    // The reciprocal is rounded down, so the quotient is low by at most one.
                    r_q     <= QW'(rec_prod >> QS);
                    r_state <= S_RED;
                end
                S_RED: begin
                    r_rem   <= r_rem - KEY_BITS'(qm_prod);
                    r_state <= S_FIX;
                end
                S_FIX: begin
                    if (XW'(r_rem) >= XW'(TOTAL_MOD)) begin
                        r_rem <= KEY_BITS'(XW'(r_rem) - XW'(TOTAL_MOD));
                    end
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    if (sum >= {1'b0, TOTAL_MOD}) begin
                        r_total <= TOTAL_W'(sum - {1'b0, TOTAL_MOD});
                    end else begin
                        r_total <= sum[TOTAL_W-1:0];
                    end
                    r_idx   <= r_pick;
                    r_state <= S_DEL_RD;
                end
                S_DEL_RD: begin
                    if (CW'(r_idx + 1'b1) < r_count) begin
                        r_state <= S_DEL_WR;
                    end else begin
                        r_count   <= CW'(r_count - 1'b1);
                        r_matched <= 1'b1;
                        r_state   <= S_OUT;
                    end
                end
                S_DEL_WR: begin
                    r_idx   <= CW'(r_idx + 1'b1);
                    r_state <= S_DEL_RD;
                end
                S_OUT: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_ovalid   <= 1'b1;
                        r_omatched <= r_matched;
                        r_odropped <= r_dropped;
                        r_odist    <= r_dist;
                        r_ototal   <= r_total;
                        r_ocount   <= r_count;
                        r_oside    <= (r_count != '0) ? r_wside : 1'b0;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

### hw/rtl/nvms_chk.sv
// Port-level checker for the nearest value match store, bound to the top level.
// Depends on nvms_pkg for the running total modulus.
`timescale 1ns / 1ps
module nvms_chk #(
    parameter int CAPACITY = 1024,
    parameter int KEY_BITS = 31
) (
    input logic                                     i_clk,
    input logic                                     i_rst_n,
    input logic                                     m_axis_tvalid,
    input logic                                     m_axis_tready,
    input logic [((KEY_BITS+nvms_pkg::TOTAL_W+$clog2(CAPACITY+1)+1+7)/8)*8-1:0]
                                                    m_axis_tdata,
    input logic [1:0]                               m_axis_tuser
);
    import nvms_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int TB = KEY_BITS;
    localparam int CB = KEY_BITS + TOTAL_W;
    localparam int SB = KEY_BITS + TOTAL_W + CW;

    a_total_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[CB-1:TB] < TOTAL_MOD))
        else $error("running total out of range");

    a_match_xor_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("request both matched and dropped");

    a_no_match_no_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[KEY_BITS-1:0] == '0))
        else $error("distance without a match");

    a_empty_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[SB-1:CB] == '0)) |-> !m_axis_tdata[SB])
        else $error("held side set with empty store");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");
endmodule

bind nearest_value_match_store nvms_chk #(.CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS)) u_nvms_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
);
